// ----- rtl/tead_pkg.sv -----
`timescale 1ns / 1ps

package tead_pkg;

  // Width of the register port and of every input field but last_pixel.
  localparam int unsigned FieldW = 16;
  // Width of the result length field.
  localparam int unsigned LenW = 33;

  // Default coordinate width and queue depths.
  localparam int unsigned CoordBitsDef  = 16;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned ResDepth      = 2;

  // Register port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgCosDir       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSinDir       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHitThreshold = 2'd2;

  localparam logic signed [FieldW-1:0] CosDirRst       = 16'sd32767;
  localparam logic signed [FieldW-1:0] SinDirRst       = 16'sd0;
  localparam logic signed [FieldW-1:0] HitThresholdRst = 16'sd0;

  // One pixel beat.
  typedef struct packed {
    logic signed [FieldW-1:0] x_pos;
    logic signed [FieldW-1:0] y_pos;
    logic signed [FieldW-1:0] content;
    logic                     last_pixel;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [LenW-1:0] length;
    logic            any_hit;
  } out_beat_t;

  // Register values handed to the front end.
  typedef struct packed {
    logic signed [FieldW-1:0] cos_dir;
    logic signed [FieldW-1:0] sin_dir;
    logic signed [FieldW-1:0] hit_threshold;
  } cfg_t;

endpackage

// ----- rtl/track_extent_along_direction.sv -----
`timescale 1ns / 1ps

// Track extent along a configured direction.
// Pixels of one image come in on the input queue port: a beat is taken when
// push is high and full is low. Each pixel whose content is above the hit
// threshold is projected as x*cos + y*sin (15 fraction bits), and the frame's
// smallest and largest projection are tracked. The pixel marked last_pixel
// closes the frame and yields one result beat: the extent (max - min) and
// a flag that the frame had a hit. A frame without hits gives zero.
// Results leave through the output queue port: the oldest result is shown
// while empty is low and is taken when pop is high.
// Throughput is one pixel per cycle while full is low, set by the registered
// multiply stage. When the receiver stalls, results collect in a two-entry
// queue and then pixels collect in the middle queue; full rises once both
// are exhausted. Reset clears the frame state and both queues and loads the
// register defaults: cos 32767, sin 0, threshold 0. The user is to write
// registers only while idle; the block itself does not enforce this.
module track_extent_along_direction #(
  parameter int unsigned COORD_BITS  = tead_pkg::CoordBitsDef,
  parameter int unsigned QUEUE_DEPTH = tead_pkg::QueueDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  tead_pkg::in_beat_t                  pix_i,
  output logic                                empty,
  input  logic                                pop,
  output tead_pkg::out_beat_t                 res_o,
  input  logic                                cfg_we_i,
  input  logic [tead_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tead_pkg::FieldW-1:0]         cfg_wdata_i
);

  localparam int unsigned ProjW = COORD_BITS + 17;
  localparam int unsigned EntW  = ProjW + 2;

  tead_pkg::cfg_t      cfg_q;
  logic                ent_valid, ent_full, ent_empty, ent_pop;
  logic [EntW-1:0]     ent_wdata, ent_rdata;
  logic                res_push, res_full;
  tead_pkg::out_beat_t res_beat;
  logic [$bits(tead_pkg::out_beat_t)-1:0] res_rdata;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_dir       <= tead_pkg::CosDirRst;
      cfg_q.sin_dir       <= tead_pkg::SinDirRst;
      cfg_q.hit_threshold <= tead_pkg::HitThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tead_pkg::CfgCosDir:       cfg_q.cos_dir       <= $signed(cfg_wdata_i);
        tead_pkg::CfgSinDir:       cfg_q.sin_dir       <= $signed(cfg_wdata_i);
        tead_pkg::CfgHitThreshold: cfg_q.hit_threshold <= $signed(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // Front end: accept, classify and project.
  tead_front #(
    .COORD_BITS (COORD_BITS),
    .PROJ_W     (ProjW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .pix_i       (pix_i),
    .full_o      (full),
    .ent_valid_o (ent_valid),
    .ent_o       (ent_wdata),
    .ent_full_i  (ent_full)
  );

  // Queue between the front and the back.
  tead_fifo #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ent_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ent_valid),
    .wdata_i (ent_wdata),
    .full_o  (ent_full),
    .pop_i   (ent_pop),
    .rdata_o (ent_rdata),
    .empty_o (ent_empty)
  );

  // Back end: running extremes and frame close.
  tead_back #(
    .PROJ_W (ProjW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_empty_i (ent_empty),
    .ent_i       (ent_rdata),
    .ent_pop_o   (ent_pop),
    .res_push_o  (res_push),
    .res_o       (res_beat),
    .res_full_i  (res_full)
  );

  // Result queue facing the receiver.
  tead_fifo #(
    .WIDTH ($bits(tead_pkg::out_beat_t)),
    .DEPTH (tead_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_beat),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_o = tead_pkg::out_beat_t'(res_rdata);

endmodule

// ----- rtl/tead_fifo.sv -----
`timescale 1ns / 1ps

module tead_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = store_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AddrW'(DEPTH - 1)) ? '0 : wptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AddrW'(DEPTH - 1)) ? '0 : rptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/tead_front.sv -----
`timescale 1ns / 1ps

module tead_front #(
  parameter int unsigned COORD_BITS = tead_pkg::CoordBitsDef,
  parameter int unsigned PROJ_W     = COORD_BITS + 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tead_pkg::cfg_t     cfg_i,
  input  logic               push_i,
  input  tead_pkg::in_beat_t pix_i,
  output logic               full_o,
  output logic               ent_valid_o,
  output logic [PROJ_W+1:0]  ent_o,
  input  logic               ent_full_i
);

  localparam int unsigned FW    = tead_pkg::FieldW;
  localparam int unsigned ProdW = COORD_BITS + FW;

  logic                     ready;
  logic                     accept;
  logic [COORD_BITS+FW-1:0] x_ext, y_ext;
  logic signed [COORD_BITS-1:0] x_c, y_c;
  logic signed [ProdW-1:0]  px_d, py_d;
  logic signed [ProdW-1:0]  px_q, py_q;
  logic                     hit_q, last_q;
  logic                     s1_valid_q;
  logic signed [PROJ_W-1:0] proj;

  // The stage may take a beat when it is empty or drains into the queue.
  assign ready  = !s1_valid_q || !ent_full_i;
  assign full_o = !ready;
  assign accept = push_i && ready;

  // Coordinates are taken from the low COORD_BITS bits of each field.
  assign x_ext = {{COORD_BITS{1'b0}}, pix_i.x_pos};
  assign y_ext = {{COORD_BITS{1'b0}}, pix_i.y_pos};
  assign x_c   = $signed(x_ext[COORD_BITS-1:0]);
  assign y_c   = $signed(y_ext[COORD_BITS-1:0]);

  // Two products in parallel, registered before the sum.
  assign px_d = ProdW'(x_c) * ProdW'(cfg_i.cos_dir);
  assign py_d = ProdW'(y_c) * ProdW'(cfg_i.sin_dir);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= px_d;
      py_q   <= py_d;
      hit_q  <= (pix_i.content > cfg_i.hit_threshold);
      last_q <= pix_i.last_pixel;
    end
  end

  // Projection sum feeds the queue entry directly.
  assign proj        = PROJ_W'(px_q) + PROJ_W'(py_q);
  assign ent_valid_o = s1_valid_q;
  assign ent_o       = {last_q, hit_q, proj};

endmodule

// ----- rtl/tead_back.sv -----
`timescale 1ns / 1ps

module tead_back #(
  parameter int unsigned PROJ_W = 33
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ent_empty_i,
  input  logic [PROJ_W+1:0]   ent_i,
  output logic                ent_pop_o,
  output logic                res_push_o,
  output tead_pkg::out_beat_t res_o,
  input  logic                res_full_i
);

  localparam int unsigned LW = tead_pkg::LenW;

  logic                     ent_last, ent_hit;
  logic signed [PROJ_W-1:0] ent_proj;
  logic signed [PROJ_W-1:0] max_q, max_d, min_q, min_d;
  logic                     seen_q, seen_d;
  logic signed [PROJ_W-1:0] fin_max_q, fin_min_q;
  logic                     fin_hit_q;
  logic                     fin_valid_q;
  logic                     fin_moves;
  logic [PROJ_W-1:0]        diff;
  logic [PROJ_W+LW-1:0]     diff_ext;

  assign ent_last = ent_i[PROJ_W+1];
  assign ent_hit  = ent_i[PROJ_W];
  assign ent_proj = $signed(ent_i[PROJ_W-1:0]);

  // A frame end waits only when the finished-frame register cannot drain.
  assign fin_moves = fin_valid_q && !res_full_i;
  assign ent_pop_o = !ent_empty_i && (!ent_last || !fin_valid_q || fin_moves);

  // Running extremes; the first hit of a frame loads both.
  always_comb begin
    max_d  = max_q;
    min_d  = min_q;
    seen_d = seen_q;
    if (ent_hit) begin
      if (!seen_q) begin
        max_d  = ent_proj;
        min_d  = ent_proj;
        seen_d = 1'b1;
      end else begin
        if (ent_proj > max_q) begin
          max_d = ent_proj;
        end
        if (ent_proj < min_q) begin
          min_d = ent_proj;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      min_q       <= '0;
      seen_q      <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      if (ent_pop_o) begin
        if (ent_last) begin
          max_q  <= '0;
          min_q  <= '0;
          seen_q <= 1'b0;
        end else begin
          max_q  <= max_d;
          min_q  <= min_d;
          seen_q <= seen_d;
        end
      end
      if (ent_pop_o && ent_last) begin
        fin_valid_q <= 1'b1;
      end else if (fin_moves) begin
        fin_valid_q <= 1'b0;
      end
    end
  end

  // Finished frame extremes, held until the result queue takes them.
  always_ff @(posedge clk_i) begin
    if (ent_pop_o && ent_last) begin
      fin_max_q <= max_d;
      fin_min_q <= min_d;
      fin_hit_q <= seen_d;
    end
  end

  // Extent is never negative, so the difference is zero-extended to the field.
  assign diff          = PROJ_W'(fin_max_q - fin_min_q);
  assign diff_ext      = {{LW{1'b0}}, diff};
  assign res_push_o    = fin_valid_q;
  assign res_o.length  = diff_ext[LW-1:0];
  assign res_o.any_hit = fin_hit_q;

endmodule
